// ===== src/trs_pkg.sv =====
// trs_pkg: types, constants and rounding helper for the model matrix block
// no dependencies; imported by every module of the block
package trs_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int QUEUE_DEPTH    = 4;
	localparam int NUM_TRIG       = 6;

	// quarter-sine polynomial constants, Q30
	localparam logic [30:0] POLY_A  = 31'd1686629713;
	localparam logic [29:0] POLY_B  = 30'd688904866;
	localparam logic [26:0] POLY_C  = 27'd76016977;
	localparam logic [30:0] Q30_ONE = 31'd1073741824;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [15:0]        angle_x;
		logic [15:0]        angle_y;
		logic [15:0]        angle_z;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] scale_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] m_r0c0;
		logic signed [31:0] m_r0c1;
		logic signed [31:0] m_r0c2;
		logic signed [31:0] m_r1c0;
		logic signed [31:0] m_r1c1;
		logic signed [31:0] m_r1c2;
		logic signed [31:0] m_r2c0;
		logic signed [31:0] m_r2c1;
		logic signed [31:0] m_r2c2;
		logic signed [31:0] trans_x;
		logic signed [31:0] trans_y;
		logic signed [31:0] trans_z;
	} out_item_t;

	// position and scale, carried alongside the arithmetic
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] scale_z;
	} side_t;

	// classified item: quarter-turn fraction and sign per sine/cosine
	// order: sin x, cos x, sin y, cos y, sin z, cos z
	typedef struct packed {
		logic [NUM_TRIG-1:0][30:0] frac;
		logic [NUM_TRIG-1:0]       neg;
		side_t                     side;
	} fe_item_t;

	// shift right by 30, rounding half away from zero
	function automatic logic signed [35:0] rnd30(input logic signed [65:0] p);
		logic        neg;
		logic [65:0] m;
		logic [35:0] r;
		neg = p[65];
		m = neg ? 66'(-p) : 66'(p);
		m = m + 66'd536870912;
		r = 36'(m >> 30);
		return neg ? -$signed(r) : $signed(r);
	endfunction

endpackage

// ===== src/trs_front.sv =====
// trs_front: input register, splits each angle into quadrant and fraction
// depends on trs_pkg
module trs_front #(
	parameter int ANGLE_BITS = trs_pkg::ANGLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  trs_pkg::in_item_t  item,
	output logic               fe_valid,
	input  logic               fe_ready,
	output trs_pkg::fe_item_t  fe
);
	import trs_pkg::*;

	localparam int QB = ANGLE_BITS - 2;

	logic     vld_q;
	fe_item_t fe_q;
	fe_item_t fe_d;
	logic [2:0][15:0] ang;

	assign ang = {item.angle_z, item.angle_y, item.angle_x};

	always_comb begin
		logic [ANGLE_BITS-1:0] a;
		logic [1:0]            quad;
		logic [30:0]           f0;
		logic [30:0]           f1;
		fe_d = '0;
		for (int k = 0; k < 3; k++) begin
			a = ANGLE_BITS'(ang[k]);
			quad = a[ANGLE_BITS-1 -: 2];
			f0 = 31'(a[QB-1:0]) << (30 - QB);
			f1 = Q30_ONE - f0;
			fe_d.frac[2*k]     = quad[0] ? f1 : f0;
			fe_d.neg[2*k]      = quad[1];
			fe_d.frac[2*k + 1] = quad[0] ? f0 : f1;
			fe_d.neg[2*k + 1]  = quad[1] ^ quad[0];
		end
		fe_d.side.pos_x   = item.pos_x;
		fe_d.side.pos_y   = item.pos_y;
		fe_d.side.pos_z   = item.pos_z;
		fe_d.side.scale_x = item.scale_x;
		fe_d.side.scale_y = item.scale_y;
		fe_d.side.scale_z = item.scale_z;
	end

	assign item_ready = !vld_q || fe_ready;
	assign fe_valid   = vld_q;
	assign fe         = fe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (item_ready) begin
			vld_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			fe_q <= fe_d;
		end
	end

endmodule

// ===== src/trs_queue.sv =====
// trs_queue: short first-in first-out queue between front and back
// depends on trs_pkg
module trs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  trs_pkg::fe_item_t  push,
	output logic               pop_valid,
	input  logic               pop_ready,
	output trs_pkg::fe_item_t  pop
);
	import trs_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	fe_item_t      mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = cnt_q != (PW+1)'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop        = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= PW'((PW+1)'(wr_q) + 1'b1 == (PW+1)'(QUEUE_DEPTH) ? 0 : wr_q + 1'b1);
			end
			if (do_pop) begin
				rd_q <= PW'((PW+1)'(rd_q) + 1'b1 == (PW+1)'(QUEUE_DEPTH) ? 0 : rd_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push;
		end
	end

endmodule

// ===== src/trs_back.sv =====
// trs_back: sine/cosine polynomials, rotation products and scaling
// depends on trs_pkg
module trs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fe_valid,
	output logic                fe_ready,
	input  trs_pkg::fe_item_t   fe,
	output logic                mat_valid,
	input  logic                mat_ready,
	output trs_pkg::out_item_t  mat
);
	import trs_pkg::*;

	localparam int NS = 10;

	logic [NS-1:0] vld_q;
	logic          en;

	logic [30:0]        f_s1 [NUM_TRIG], f_s2 [NUM_TRIG], f_s3 [NUM_TRIG];
	logic [30:0]        f2_s1 [NUM_TRIG], f2_s2 [NUM_TRIG];
	logic [NUM_TRIG-1:0] neg_s1, neg_s2, neg_s3;
	logic [29:0]        t1_s2 [NUM_TRIG];
	logic [30:0]        t2_s3 [NUM_TRIG];
	logic signed [31:0] trig_s4 [NUM_TRIG], trig_s5 [NUM_TRIG], trig_s6 [NUM_TRIG];
	logic signed [63:0] p_s5 [10];
	logic signed [31:0] q_s6 [10], q_s7 [10];
	logic signed [63:0] pb_s7 [4];
	logic signed [31:0] sx_s7;
	logic signed [32:0] r_s8 [9];
	logic signed [65:0] pr_s9 [9];
	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	side_t side_s9;
	out_item_t out_s10;

	logic signed [32:0] lb [4];
	logic signed [32:0] qe [10];
	logic signed [31:0] res [9];

	// whole pipeline advances together unless the result is held
	assign en        = !vld_q[NS-1] || mat_ready;
	assign fe_ready  = en;
	assign mat_valid = vld_q[NS-1];
	assign mat       = out_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NS-2:0], fe_valid};
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			lb[k] = 33'(rnd30(66'(pb_s7[k])));
		end
		for (int k = 0; k < 10; k++) begin
			qe[k] = 33'(q_s7[k]);
		end
		for (int i = 0; i < 9; i++) begin
			logic signed [35:0] v;
			v = rnd30(pr_s9[i]);
			if (v > 36'sd2147483647) begin
				res[i] = 32'sh7fffffff;
			end else if (v < -36'sd2147483648) begin
				res[i] = 32'sh80000000;
			end else begin
				res[i] = 32'(v);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			logic [61:0] m1;
			logic [57:0] m2;
			logic [60:0] m3;
			logic [61:0] m4;
			logic [30:0] sv;
			for (int u = 0; u < NUM_TRIG; u++) begin
				// f squared
				m1 = fe.frac[u] * fe.frac[u];
				f_s1[u]  <= fe.frac[u];
				f2_s1[u] <= m1[60:30];
				// B - C f^2
				m2 = POLY_C * f2_s1[u];
				f_s2[u]  <= f_s1[u];
				f2_s2[u] <= f2_s1[u];
				t1_s2[u] <= POLY_B - 30'(m2[57:30]);
				// A - f^2 (B - C f^2)
				m3 = t1_s2[u] * f2_s2[u];
				f_s3[u]  <= f_s2[u];
				t2_s3[u] <= POLY_A - m3[60:30];
				// times f, clamp at one, apply quadrant sign
				m4 = t2_s3[u] * f_s3[u];
				sv = (m4[61:30] > 32'(Q30_ONE)) ? Q30_ONE : m4[60:30];
				trig_s4[u] <= neg_s3[u] ? -$signed({1'b0, sv}) : $signed({1'b0, sv});
				trig_s5[u] <= trig_s4[u];
				trig_s6[u] <= trig_s5[u];
			end
			neg_s1 <= fe.neg;
			neg_s2 <= neg_s1;
			neg_s3 <= neg_s2;

			// first level of products, trig order sx cx sy cy sz cz
			p_s5[0] <= trig_s4[2] * trig_s4[0];
			p_s5[1] <= trig_s4[3] * trig_s4[0];
			p_s5[2] <= trig_s4[3] * trig_s4[5];
			p_s5[3] <= trig_s4[3] * trig_s4[4];
			p_s5[4] <= trig_s4[2] * trig_s4[1];
			p_s5[5] <= trig_s4[1] * trig_s4[4];
			p_s5[6] <= trig_s4[1] * trig_s4[5];
			p_s5[7] <= trig_s4[2] * trig_s4[4];
			p_s5[8] <= trig_s4[2] * trig_s4[5];
			p_s5[9] <= trig_s4[3] * trig_s4[1];
			for (int k = 0; k < 10; k++) begin
				q_s6[k] <= 32'(rnd30(66'(p_s5[k])));
				q_s7[k] <= q_s6[k];
			end

			// second level: sy sx and cy sx against sz and cz
			pb_s7[0] <= q_s6[0] * trig_s6[4];
			pb_s7[1] <= q_s6[0] * trig_s6[5];
			pb_s7[2] <= q_s6[1] * trig_s6[4];
			pb_s7[3] <= q_s6[1] * trig_s6[5];
			sx_s7    <= trig_s6[0];

			r_s8[0] <= qe[2] + lb[0];
			r_s8[1] <= lb[1] - qe[3];
			r_s8[2] <= qe[4];
			r_s8[3] <= qe[5];
			r_s8[4] <= qe[6];
			r_s8[5] <= -33'(sx_s7);
			r_s8[6] <= lb[2] - qe[8];
			r_s8[7] <= qe[7] + lb[3];
			r_s8[8] <= qe[9];

			pr_s9[0] <= r_s8[0] * side_s8.scale_x;
			pr_s9[1] <= r_s8[1] * side_s8.scale_y;
			pr_s9[2] <= r_s8[2] * side_s8.scale_z;
			pr_s9[3] <= r_s8[3] * side_s8.scale_x;
			pr_s9[4] <= r_s8[4] * side_s8.scale_y;
			pr_s9[5] <= r_s8[5] * side_s8.scale_z;
			pr_s9[6] <= r_s8[6] * side_s8.scale_x;
			pr_s9[7] <= r_s8[7] * side_s8.scale_y;
			pr_s9[8] <= r_s8[8] * side_s8.scale_z;

			out_s10.m_r0c0  <= res[0];
			out_s10.m_r0c1  <= res[1];
			out_s10.m_r0c2  <= res[2];
			out_s10.m_r1c0  <= res[3];
			out_s10.m_r1c1  <= res[4];
			out_s10.m_r1c2  <= res[5];
			out_s10.m_r2c0  <= res[6];
			out_s10.m_r2c1  <= res[7];
			out_s10.m_r2c2  <= res[8];
			out_s10.trans_x <= side_s9.pos_x;
			out_s10.trans_y <= side_s9.pos_y;
			out_s10.trans_z <= side_s9.pos_z;

			side_s1 <= fe.side;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
			side_s7 <= side_s6;
			side_s8 <= side_s7;
			side_s9 <= side_s8;
		end
	end

endmodule

// ===== src/trs_model_matrix.sv =====
// trs_model_matrix: top level of the model matrix block
// depends on trs_pkg, trs_front, trs_queue, trs_back
//
// forms M = T * Ry * Rx * Rz * S from a position, three binary angles and a
// per-axis scale, one transfer on item per clock when mat is taken; mat valid
// rises after the item passes twelve registers (front register, queue entry,
// ten back stages) and the throughput of one per cycle is set by the back
// pipeline, which holds as a whole while a result waits.
// a front register classifies the angles into quadrant and fraction and
// feeds a four-entry queue, so the input side keeps taking transfers for a
// while after the output stalls. sine and cosine come from a quarter-wave
// polynomial in Q30, rotation entries are rounded half away from zero,
// scaled entries saturate to the 32 bit range and the translation passes
// straight through
module trs_model_matrix #(
	parameter int ANGLE_BITS = trs_pkg::ANGLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  trs_pkg::in_item_t   item,
	output logic                mat_valid,
	input  logic                mat_ready,
	output trs_pkg::out_item_t  mat
);
	import trs_pkg::*;

	// front to queue
	logic     fe_valid;
	logic     fe_ready;
	fe_item_t fe;

	// queue to back
	logic     bk_valid;
	logic     bk_ready;
	fe_item_t bk;

	trs_front #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.fe_valid   (fe_valid),
		.fe_ready   (fe_ready),
		.fe         (fe)
	);

	trs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.push       (fe),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop        (bk)
	);

	trs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fe_valid  (bk_valid),
		.fe_ready  (bk_ready),
		.fe        (bk),
		.mat_valid (mat_valid),
		.mat_ready (mat_ready),
		.mat       (mat)
	);

endmodule

// ===== tb/tb_trs_model_matrix.sv =====
// tb_trs_model_matrix: self-checking testbench for the model matrix block
// depends on trs_pkg and trs_model_matrix; predicts each matrix in the bench
`timescale 1ns / 100ps

module tb_trs_model_matrix;
	import trs_pkg::*;

	localparam int LATENCY   = 12;
	localparam int MAX_GAP   = 12;
	localparam int N_RANDOM  = 450;
	localparam int CYC_LIMIT = 200000;

	// quarter-wave polynomial constants, Q30
	localparam longint unsigned K_A = 64'd1686629713;
	localparam longint unsigned K_B = 64'd688904866;
	localparam longint unsigned K_C = 64'd76016977;
	localparam longint ONE_Q30      = 64'sd1073741824;

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_ready;
	in_item_t   item;
	logic       mat_valid;
	logic       mat_ready;
	out_item_t  mat;

	in_item_t   pending_items[$];
	out_item_t  expected_mats[$];
	int         n_errors;
	int         n_sent;
	int         n_checked;
	int         cycle_count;
	int         send_wait;
	int         take_wait;
	bit         hold_send;
	bit         item_taken;
	bit         mat_taken;

	trs_model_matrix u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.mat_valid  (mat_valid),
		.mat_ready  (mat_ready),
		.mat        (mat)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// sin(pi/2 * f) in Q30, every product truncated
	function automatic longint quarter_wave(input longint unsigned f);
		longint unsigned f2;
		longint unsigned t;
		f2 = (f * f) >> 30;
		t = (K_C * f2) >> 30;
		t = K_B - t;
		t = (t * f2) >> 30;
		t = K_A - t;
		t = (t * f) >> 30;
		if (t > 64'd1073741824)
			t = 64'd1073741824;
		return longint'(t);
	endfunction

	function automatic longint sine_of(input logic [15:0] ang);
		logic [1:0]       quad;
		longint unsigned  f;
		longint           v;
		quad = ang[15:14];
		f = longint'(ang[13:0]) << 16;
		if (quad[0])
			f = 64'd1073741824 - f;
		v = quarter_wave(f);
		return quad[1] ? -v : v;
	endfunction

	// shift by 30, half away from zero
	function automatic longint round_q30(input longint p);
		longint unsigned m;
		m = (p < 0) ? longint'(-p) : longint'(p);
		m = (m + 64'd536870912) >> 30;
		return (p < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic signed [31:0] scaled_entry(input longint r,
			input logic signed [31:0] s);
		longint v;
		v = round_q30(r * longint'(s));
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic out_item_t model_matrix(input in_item_t it);
		longint sx, cx, sy, cy, sz, cz, sysx, cysx;
		longint r[9];
		out_item_t o;
		sx = sine_of(it.angle_x);
		cx = sine_of(it.angle_x + 16'h4000);
		sy = sine_of(it.angle_y);
		cy = sine_of(it.angle_y + 16'h4000);
		sz = sine_of(it.angle_z);
		cz = sine_of(it.angle_z + 16'h4000);
		sysx = round_q30(sy * sx);
		cysx = round_q30(cy * sx);
		// rotation about y, then x, then z
		r[0] = round_q30(cy * cz) + round_q30(sysx * sz);
		r[1] = round_q30(sysx * cz) - round_q30(cy * sz);
		r[2] = round_q30(sy * cx);
		r[3] = round_q30(cx * sz);
		r[4] = round_q30(cx * cz);
		r[5] = -sx;
		r[6] = round_q30(cysx * sz) - round_q30(sy * cz);
		r[7] = round_q30(sy * sz) + round_q30(cysx * cz);
		r[8] = round_q30(cy * cx);
		// column j scaled by the scale along axis j
		o.m_r0c0 = scaled_entry(r[0], it.scale_x);
		o.m_r0c1 = scaled_entry(r[1], it.scale_y);
		o.m_r0c2 = scaled_entry(r[2], it.scale_z);
		o.m_r1c0 = scaled_entry(r[3], it.scale_x);
		o.m_r1c1 = scaled_entry(r[4], it.scale_y);
		o.m_r1c2 = scaled_entry(r[5], it.scale_z);
		o.m_r2c0 = scaled_entry(r[6], it.scale_x);
		o.m_r2c1 = scaled_entry(r[7], it.scale_y);
		o.m_r2c2 = scaled_entry(r[8], it.scale_z);
		o.trans_x = it.pos_x;
		o.trans_y = it.pos_y;
		o.trans_z = it.pos_z;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		n_errors++;
		$display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what,
			got, want);
	endtask

	// mixed scale: full range, within 4 or 128 of zero, or exactly plus or minus one
	function automatic logic [31:0] pick_scale();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
			2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
			default: return 32'($signed($urandom_range(0, 256 << 16)) - (128 << 16));
		endcase
	endfunction

	function automatic logic [15:0] pick_angle();
		case ($urandom_range(0, 4))
			0: return 16'($urandom_range(0, 3) << 14);
			1: return 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 2) - 1);
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		it.pos_x   = $urandom();
		it.pos_y   = $urandom();
		it.pos_z   = $urandom();
		it.angle_x = pick_angle();
		it.angle_y = pick_angle();
		it.angle_z = pick_angle();
		it.scale_x = pick_scale();
		it.scale_y = pick_scale();
		it.scale_z = pick_scale();
		return it;
	endfunction

	function automatic in_item_t directed_item(input logic [31:0] p,
			input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az,
			input logic [31:0] s);
		in_item_t it;
		it.pos_x = p;
		it.pos_y = ~p;
		it.pos_z = p ^ 32'h5A5A_A5A5;
		it.angle_x = ax;
		it.angle_y = ay;
		it.angle_z = az;
		it.scale_x = s;
		it.scale_y = s;
		it.scale_z = s;
		return it;
	endfunction

	// driver: changes inputs on the falling edge, random gap between items
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			send_wait <= 0;
		end else if (item_valid && !item_taken) begin
			// held until the transfer
		end else if (send_wait > 0) begin
			item_valid <= 1'b0;
			send_wait <= send_wait - 1;
		end else if (pending_items.size() > 0 && !hold_send) begin
			item_valid <= 1'b1;
			item <= pending_items.pop_front();
			send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
		end else begin
			item_valid <= 1'b0;
		end
	end

	// receiver stall, drawn afresh per result
	always @(negedge clk or negedge arst_n) begin
		int w;
		if (!arst_n) begin
			mat_ready <= 1'b0;
			take_wait <= 0;
		end else if (mat_taken) begin
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
			take_wait <= w;
			mat_ready <= (w == 0);
		end else if (take_wait > 0) begin
			mat_ready <= 1'b0;
			take_wait <= take_wait - 1;
		end else begin
			mat_ready <= 1'b1;
		end
	end

	// monitor: predict on each item transfer, check on each mat transfer
	always @(posedge clk) begin
		out_item_t want;
		item_taken <= item_valid && item_ready;
		mat_taken <= mat_valid && mat_ready;
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (item_valid && item_ready) begin
				expected_mats.push_back(model_matrix(item));
				n_sent <= n_sent + 1;
			end
			if (mat_valid && mat_ready) begin
				if (expected_mats.size() == 0) begin
					n_errors++;
					$display("unexpected matrix transfer at cycle %0d", cycle_count);
				end else begin
					want = expected_mats.pop_front();
					n_checked <= n_checked + 1;
					if (mat.m_r0c0 !== want.m_r0c0) report_mismatch("m_r0c0", mat.m_r0c0, want.m_r0c0);
					if (mat.m_r0c1 !== want.m_r0c1) report_mismatch("m_r0c1", mat.m_r0c1, want.m_r0c1);
					if (mat.m_r0c2 !== want.m_r0c2) report_mismatch("m_r0c2", mat.m_r0c2, want.m_r0c2);
					if (mat.m_r1c0 !== want.m_r1c0) report_mismatch("m_r1c0", mat.m_r1c0, want.m_r1c0);
					if (mat.m_r1c1 !== want.m_r1c1) report_mismatch("m_r1c1", mat.m_r1c1, want.m_r1c1);
					if (mat.m_r1c2 !== want.m_r1c2) report_mismatch("m_r1c2", mat.m_r1c2, want.m_r1c2);
					if (mat.m_r2c0 !== want.m_r2c0) report_mismatch("m_r2c0", mat.m_r2c0, want.m_r2c0);
					if (mat.m_r2c1 !== want.m_r2c1) report_mismatch("m_r2c1", mat.m_r2c1, want.m_r2c1);
					if (mat.m_r2c2 !== want.m_r2c2) report_mismatch("m_r2c2", mat.m_r2c2, want.m_r2c2);
					if (mat.trans_x !== want.trans_x) report_mismatch("trans_x", mat.trans_x, want.trans_x);
					if (mat.trans_y !== want.trans_y) report_mismatch("trans_y", mat.trans_y, want.trans_y);
					if (mat.trans_z !== want.trans_z) report_mismatch("trans_z", mat.trans_z, want.trans_z);
				end
			end
			if (cycle_count >= CYC_LIMIT) begin
				$display("timeout with %0d matrices outstanding", expected_mats.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		int total;
		n_errors = 0;
		n_sent = 0;
		n_checked = 0;
		cycle_count = 0;
		hold_send = 1'b0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		mat_ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero angles, quadrant edges, field extremes, saturation
		pending_items.push_back(directed_item(32'h0, 16'h0, 16'h0, 16'h0, 32'h0001_0000));
		pending_items.push_back(directed_item(32'h8000_0000, 16'h4000, 16'h0, 16'h0, 32'h0001_0000));
		pending_items.push_back(directed_item(32'h7FFF_FFFF, 16'h0, 16'h4000, 16'h0, 32'h0001_0000));
		pending_items.push_back(directed_item(32'h1234_5678, 16'h0, 16'h0, 16'h4000, 32'h0001_0000));
		pending_items.push_back(directed_item(32'hFFFF_FFFF, 16'h8000, 16'h8000, 16'h8000, 32'h0002_0000));
		pending_items.push_back(directed_item(32'h0000_0001, 16'hC000, 16'hC000, 16'hC000, 32'hFFFF_0000));
		pending_items.push_back(directed_item(32'hDEAD_BEEF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF));
		pending_items.push_back(directed_item(32'h0BAD_F00D, 16'h2000, 16'h6000, 16'hA000, 32'h8000_0000));
		pending_items.push_back(directed_item(32'h0, 16'h3FFF, 16'h4001, 16'h7FFF, 32'h7FFF_FFFF));
		pending_items.push_back(directed_item(32'h0, 16'h1000, 16'h1000, 16'h1000, 32'h0));
		pending_items.push_back(directed_item(32'h5555_5555, 16'h0001, 16'hBFFF, 16'hC001, 32'h8000_0000));
		pending_items.push_back(directed_item(32'hAAAA_AAAA, 16'h5555, 16'hAAAA, 16'h0000, 32'hFFFF_FFFF));
		pending_items.push_back(directed_item(32'h0, 16'h2000, 16'h2000, 16'h2000, 32'h0000_0001));

		// wait until every matrix has been checked, then pause the sender while queueing
		wait (pending_items.size() == 0 && !item_valid && expected_mats.size() == 0);
		hold_send = 1'b1;
		for (int k = 0; k < N_RANDOM; k++)
			pending_items.push_back(random_item());
		@(negedge clk);
		hold_send = 1'b0;

		wait (pending_items.size() == 0 && !item_valid);
		wait (expected_mats.size() == 0);
		repeat (4 * LATENCY) @(posedge clk);
		total = n_checked;
		$display("checked %0d matrices from %0d item transfers, directed angle edges and",
			total, n_sent);
		$display("random angles, positions and scales with random stalls on both sides");
		if (n_errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
